/* design/assert_macros.svh */
// Assertion macros for the RTL that carries concurrent checks (indexed_list_store).
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clock, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that post holds in the cycle after pre, off while reset is high.
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* design/ils_pkg.sv */
// Package for the indexed list store: sizes, operation and status codes,
// and the sequencer state type. No dependencies.
package ils_pkg;

   localparam int CAPACITY      = 64;
   localparam int ELEMENT_WIDTH = 32;
   localparam int ADDR_W        = $clog2(CAPACITY);
   localparam int COUNT_W       = $clog2(CAPACITY + 1);

   typedef logic [ELEMENT_WIDTH-1:0] elem_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [COUNT_W-1:0]       count_type;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_INSERT = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_BADIDX = 2'd3;

   localparam count_type CAP_RESET = count_type'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_INS_WR,
      S_INS_VAL,
      S_POP_CAP,
      S_RM_FIRST,
      S_RM_SH,
      S_DONE
   } state_type;

endpackage

/* design/indexed_list_store.sv */
// Indexed list store top level: sequencer, element memory and channels.
// Depends on ils_pkg and assert_macros.svh.
//
// Usage:
//   req_ channel carries one transaction: op (push, pop, remove-at, insert-at),
//   position and value_in. It is taken when req_valid is high and req_stall
//   is low. req_stall is high while a transaction is being worked on.
//   rsp_ channel returns one transaction per request: value_out, status and
//   count_out (length after the request). It is held while rsp_stall is high.
//   csr_ channel writes active_capacity; csr_ready is always high.
// Sequencer states per request (count is the length before the request):
//   push, insert past the end, full, empty and bad-index results: decode,
//   done. pop: decode, read capture, done. insert-at: decode, a shift step
//   for each element from position to count - 1, value write, done.
//   remove-at: decode, first read, a shift step for each later element, done.
//   The element memory has one write and one registered read port, so a
//   shift moves one element per cycle; the next request is taken the cycle
//   after the result is loaded into the output register.
// Reset clears the count to zero and the capacity to its full value; the
// element memory is not cleared. When the receiver stalls, the finished
// result waits in the sequencer until the output register frees up.
`include "assert_macros.svh"

module indexed_list_store import ils_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [5:0]  req_position,
   input  logic [31:0] req_value_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value_out,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_count_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_active_capacity
);

   state_type state_ff, state_in;
   count_type count_ff, count_in;
   count_type cap_ff;
   count_type limit;
   addr_type  ptr_ff, ptr_in;
   logic [1:0] op_ff;
   addr_type   pos_ff;
   elem_type   val_ff;
   elem_type   result_ff, result_in;
   logic [1:0] status_ff, status_in;

   logic       rsp_valid_ff, rsp_valid_in;
   elem_type   rsp_value_ff;
   logic [1:0] rsp_status_ff;
   count_type  rsp_count_ff;

   elem_type mem [CAPACITY];
   elem_type rd_data_ff;
   logic     mem_we;
   addr_type mem_waddr, mem_raddr;
   elem_type mem_wdata;

   logic req_take;
   logic rsp_load;

   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // Clamp capacity to 1..CAPACITY
   always_comb begin
      if (cap_ff == '0) begin
         limit = count_type'(1);
      end else if (cap_ff > count_type'(CAPACITY)) begin
         limit = count_type'(CAPACITY);
      end else begin
         limit = cap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_active_capacity;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      result_ff <= result_in;
      status_ff <= status_in;
      if (req_take) begin
         op_ff  <= req_op;
         pos_ff <= req_position;
         val_ff <= req_value_in;
      end
      if (rsp_load) begin
         rsp_value_ff  <= result_ff;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      result_in    = result_ff;
      status_in    = status_ff;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff;
      mem_wdata    = rd_data_ff;
      mem_raddr    = ptr_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            result_in = '0;
            status_in = ST_OK;
            state_in  = S_DONE;
            case (op_ff)
               OP_PUSH, OP_INSERT: begin
                  if (count_ff >= limit) begin
                     status_in = ST_FULL;
                  end else if (op_ff == OP_PUSH || {1'b0, pos_ff} >= count_ff) begin
                     mem_we    = 1'b1;
                     mem_waddr = count_ff[ADDR_W-1:0];
                     mem_wdata = val_ff;
                     count_in  = count_ff + count_type'(1);
                  end else begin
                     // open a gap: walk down from the last element
                     ptr_in    = addr_type'(count_ff - count_type'(1));
                     mem_raddr = addr_type'(count_ff - count_type'(1));
                     count_in  = count_ff + count_type'(1);
                     state_in  = S_INS_WR;
                  end
               end
               OP_POP: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     mem_raddr = addr_type'(count_ff - count_type'(1));
                     count_in  = count_ff - count_type'(1);
                     state_in  = S_POP_CAP;
                  end
               end
               default: begin
                  if ({1'b0, pos_ff} >= count_ff) begin
                     status_in = ST_BADIDX;
                  end else begin
                     mem_raddr = pos_ff;
                     ptr_in    = pos_ff;
                     count_in  = count_ff - count_type'(1);
                     state_in  = S_RM_FIRST;
                  end
               end
            endcase
         end
         S_INS_WR: begin
            // move element ptr up by one, fetch the one below
            mem_we    = 1'b1;
            mem_waddr = ptr_ff + addr_type'(1);
            mem_wdata = rd_data_ff;
            mem_raddr = ptr_ff - addr_type'(1);
            if (ptr_ff == pos_ff) begin
               state_in = S_INS_VAL;
            end else begin
               ptr_in = ptr_ff - addr_type'(1);
            end
         end
         S_INS_VAL: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = val_ff;
            state_in  = S_DONE;
         end
         S_POP_CAP: begin
            result_in = rd_data_ff;
            state_in  = S_DONE;
         end
         S_RM_FIRST: begin
            result_in = rd_data_ff;
            mem_raddr = ptr_ff + addr_type'(1);
            if ({1'b0, ptr_ff} == count_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_RM_SH;
            end
         end
         S_RM_SH: begin
            // move element ptr+1 down by one, fetch the next
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = rd_data_ff;
            mem_raddr = ptr_ff + addr_type'(2);
            if ({1'b0, ptr_ff} + count_type'(1) == count_ff) begin
               state_in = S_DONE;
            end else begin
               ptr_in = ptr_ff + addr_type'(1);
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count_out = rsp_count_ff;

   `ASSERT_CLK(a_count_bound, count_ff <= count_type'(CAPACITY), "count exceeds capacity")
   `ASSERT_NEXT(a_take_decode, req_valid && !req_stall, state_ff == S_DECODE,
                "accept did not decode")
   `ASSERT_NEXT(a_load_valid, rsp_load, rsp_valid, "result load lost")
   `ASSERT_NEXT(a_count_step, state_ff != S_DECODE, $stable(count_ff),
                "count changed outside decode")

endmodule

/* dv/ils_list_checker.sv */
// List checker: watches the request, result and capacity channels of the
// indexed list store, predicts every result and compares. Depends on ils_pkg.
`timescale 1ns / 100ps

module ils_list_checker import ils_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [5:0]  req_position,
   input  logic [31:0] req_value_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_value_out,
   input  logic [1:0]  rsp_status,
   input  logic [6:0]  rsp_count_out,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [6:0]  csr_active_capacity,
   output int          mismatch_count,
   output int          results_pending,
   output int          list_length
);

   typedef struct packed {
      elem_type   value;
      logic [1:0] status;
      count_type  count;
   } list_result_type;

   elem_type        list_slots [CAPACITY];
   count_type       list_len;
   logic [6:0]      capacity_reg;
   list_result_type pending_results [$];

   // Clamp the programmed capacity to 1..CAPACITY.
   function automatic int capacity_limit();
      if (capacity_reg == 7'd0) return 1;
      if (capacity_reg > CAPACITY) return CAPACITY;
      return int'(capacity_reg);
   endfunction

   function automatic list_result_type apply_list_op(logic [1:0] op, addr_type pos,
                                                     elem_type val);
      list_result_type r;
      int              n;
      r.value  = '0;
      r.status = ST_OK;
      n        = int'(list_len);
      case (op)
         OP_PUSH, OP_INSERT: begin
            if (n >= capacity_limit()) begin
               r.status = ST_FULL;
            end else begin
               if (op == OP_PUSH || pos >= n) begin
                  list_slots[n] = val;
               end else begin
                  // open a gap at pos
                  for (int i = n; i > pos; i--) list_slots[i] = list_slots[i - 1];
                  list_slots[pos] = val;
               end
               list_len = count_type'(n + 1);
            end
         end
         OP_POP: begin
            if (n == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.value  = list_slots[n - 1];
               list_len = count_type'(n - 1);
            end
         end
         default: begin
            if (pos >= n) begin
               r.status = ST_BADIDX;
            end else begin
               r.value = list_slots[pos];
               // close the gap
               for (int i = pos; i + 1 < n; i++) list_slots[i] = list_slots[i + 1];
               list_len = count_type'(n - 1);
            end
         end
      endcase
      r.count = list_len;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t ns list check: %s got %0h want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         list_len     = '0;
         capacity_reg = CAP_RESET;
         pending_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result transaction with nothing pending",
                               rsp_value_out, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_value_out !== want.value)
                  report_mismatch("value_out", rsp_value_out, want.value);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_count_out !== want.count)
                  report_mismatch("count_out", rsp_count_out, want.count);
            end
         end
         if (csr_valid && csr_ready) capacity_reg = csr_active_capacity;
         if (req_valid && !req_stall)
            pending_results.push_back(apply_list_op(req_op, req_position, req_value_in));
      end
      results_pending = pending_results.size();
      list_length     = int'(list_len);
   end

endmodule

/* dv/tb_top.sv */
// Testbench top for the indexed list store: clock, reset, request and
// capacity stimulus, result stall and verdict. Depends on ils_pkg, the
// store RTL and ils_list_checker.
`timescale 1ns / 100ps

module tb_top import ils_pkg::*; ();

   localparam int IDLE_LIMIT  = 4000;
   localparam int PHASE_ITEMS = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_PUSH;
   logic [5:0]  req_position = '0;
   logic [31:0] req_value_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_value_out;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_count_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_active_capacity = 7'd64;

   int mismatch_count;
   int results_pending;
   int list_length;
   bit quiet = 1'b0;
   int fill_bias = 50;
   int stall_left = 0;
   int idle_cycles = 0;

   always #6 clock = ~clock;

   indexed_list_store i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_position        (req_position),
      .req_value_in        (req_value_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_value_out       (rsp_value_out),
      .rsp_status          (rsp_status),
      .rsp_count_out       (rsp_count_out),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_active_capacity (csr_active_capacity)
   );

   ils_list_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_position        (req_position),
      .req_value_in        (req_value_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_value_out       (rsp_value_out),
      .rsp_status          (rsp_status),
      .rsp_count_out       (rsp_count_out),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_active_capacity (csr_active_capacity),
      .mismatch_count      (mismatch_count),
      .results_pending     (results_pending),
      .list_length         (list_length)
   );

   // Mostly none or short, now and then long.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   always @(negedge clock) begin
      if (stall_left == 0 && !quiet) stall_left = idle_length();
      if (quiet) stall_left = 0;
      rsp_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Enter and leave at a falling edge; hold the payload until taken.
   task automatic send_request(logic [1:0] op, logic [5:0] pos, logic [31:0] val);
      int gap;
      gap = quiet ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_position <= pos;
      req_value_in <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Write only with the store drained and settled.
   task automatic write_capacity(logic [6:0] cap);
      req_valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      csr_valid           <= 1'b1;
      csr_active_capacity <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_request();
      int          roll;
      int          hi;
      logic [1:0]  op;
      logic [5:0]  pos;
      logic [31:0] val;
      roll = $urandom_range(0, 99);
      if (roll < fill_bias) op = $urandom_range(0, 1) ? OP_PUSH : OP_INSERT;
      else                  op = $urandom_range(0, 1) ? OP_POP : OP_REMOVE;
      // keep most positions inside the list, insert may point one past the end
      if (op == OP_INSERT) hi = (list_length > 63) ? 63 : list_length;
      else                 hi = (list_length > 0) ? list_length - 1 : 0;
      roll = $urandom_range(0, 99);
      if (roll < 80)      pos = 6'($urandom_range(0, hi));
      else if (roll < 86) pos = 6'd63;
      else                pos = 6'($urandom);
      roll = $urandom_range(0, 9);
      if (roll == 0)      val = '0;
      else if (roll == 1) val = '1;
      else                val = $urandom;
      send_request(op, pos, val);
   endtask

   initial begin
      logic [6:0] cap;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list refuses pop and remove; then fill, insert, remove (one bad index) and drain
      send_request(OP_POP, 6'd0, 32'h0);
      send_request(OP_REMOVE, 6'd0, 32'h0);
      send_request(OP_REMOVE, 6'd63, 32'hFFFF_FFFF);
      send_request(OP_PUSH, 6'd63, 32'h0);
      send_request(OP_PUSH, 6'd0, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 6'd0, 32'hA5A5_A5A5);
      send_request(OP_INSERT, 6'd1, 32'h5A5A_5A5A);
      send_request(OP_INSERT, 6'd63, 32'h1234_5678);
      send_request(OP_REMOVE, 6'd5, 32'h0);
      send_request(OP_REMOVE, 6'd0, 32'h0);
      send_request(OP_REMOVE, 6'd3, 32'h0);
      send_request(OP_REMOVE, 6'd1, 32'h0);
      send_request(OP_POP, 6'd0, 32'h0);
      send_request(OP_POP, 6'd0, 32'h0);

      write_capacity(7'd1);
      send_request(OP_PUSH, 6'd0, 32'h8000_0001);
      send_request(OP_PUSH, 6'd0, 32'h7FFF_FFFE);
      send_request(OP_INSERT, 6'd0, 32'h0F0F_0F0F);
      send_request(OP_INSERT, 6'd63, 32'hF0F0_F0F0);

      // zero acts as one
      write_capacity(7'd0);
      send_request(OP_POP, 6'd0, 32'h0);
      send_request(OP_PUSH, 6'd0, 32'hDEAD_BEEF);
      send_request(OP_PUSH, 6'd0, 32'hCAFE_F00D);

      write_capacity(7'd127);
      send_request(OP_PUSH, 6'd0, 32'h1);
      send_request(OP_INSERT, 6'd0, 32'h2);

      // limit below the stored count: push refused, removals work, then an insert fits
      write_capacity(7'd2);
      send_request(OP_PUSH, 6'd0, 32'h3);
      send_request(OP_REMOVE, 6'd0, 32'h0);
      send_request(OP_POP, 6'd0, 32'h0);
      send_request(OP_INSERT, 6'd0, 32'h4);

      for (int ph = 0; ph < 9; ph++) begin
         case (ph)
            0:       cap = 7'd64;
            1:       cap = 7'd127;
            2:       cap = 7'($urandom_range(1, 64));
            3:       cap = 7'd0;
            4:       cap = 7'd1;
            5:       cap = 7'd96;
            6:       cap = 7'd2;
            7:       cap = 7'($urandom_range(0, 127));
            default: cap = 7'd64;
         endcase
         write_capacity(cap);
         quiet <= (ph % 4 == 3);
         case (ph % 3)
            0:       fill_bias = 80;
            1:       fill_bias = 50;
            default: fill_bias = 25;
         endcase
         repeat (PHASE_ITEMS) random_request();
      end

      req_valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
